>>> design/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and round functions for the SHA-256 digest core.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int LEN_OFFSET  = 56;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Controller states.
    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_ROUNDS,
        ST_FINISH,
        ST_PAD,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_byte;    // write data byte into the block store
        logic       start_block;  // copy hash words into working registers
        logic       round_en;     // run one compression round
        logic       finish_block; // add working registers into hash words
        logic       pad_write;    // write one padding byte at the fill point
        logic       pad_mark;     // the padding byte is the 0x80 marker
        logic       pad_len;      // this block carries the bit length
        logic       count_block;  // add 512 to the bit count
        logic       clear_fill;   // restart the fill count
        logic       add_tail;     // add the tail bits to the bit count
        logic       reinit;       // back to the initial hash values
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [5:0] fill;
        logic       last_round;
    } dp_stat_t;

    typedef logic [31:0] word_t;

    function automatic word_t hash_init(input logic [2:0] idx);
        word_t v;
        unique case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t ror(input word_t v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

>>> design/sha_datapath.sv
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Message schedule window (which also gathers the block bytes), round
// registers, hash words and bit count.
// ----------------------------------------------------------------------------
module sha_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sha_pkg::dp_cmd_t     cmd,
    input  logic [7:0]           data_byte,
    output sha_pkg::dp_stat_t    stat,
    output logic [255:0]         digest
);

    logic [5:0]          fill_reg;
    logic [5:0]          round_reg;
    logic [63:0]         bits_reg;
    sha_pkg::word_t      hash_reg [8];
    sha_pkg::word_t      work_reg [8];
    sha_pkg::word_t      sched_reg [16];
    logic [7:0]          wr_byte;
    logic                wr_en;
    sha_pkg::word_t      w_cur;
    sha_pkg::word_t      w_new;
    sha_pkg::word_t      t1;
    sha_pkg::word_t      t2;
    logic [7:0]          len_byte;

    // Length byte for the last eight positions of the final block.
    always_comb
    begin
        len_byte = bits_reg[8 * (7 - 32'(fill_reg[2:0])) +: 8];
    end

    // Byte written into the block: data, pad marker, zero or length.
    always_comb
    begin
        wr_en   = cmd.load_byte | cmd.pad_write;
        wr_byte = data_byte;
        if (cmd.pad_write)
        begin
            if (cmd.pad_mark)
                wr_byte = sha_pkg::PAD_BYTE;
            else if (cmd.pad_len && fill_reg >= 6'(sha_pkg::LEN_OFFSET))
                wr_byte = len_byte;
            else
                wr_byte = 8'h00;
        end
    end

    // Schedule word for this round and the next window entry.
    always_comb
    begin
        w_cur = sched_reg[0];
        w_new = sched_reg[0]
              + (sha_pkg::ror(sched_reg[1], 7) ^ sha_pkg::ror(sched_reg[1], 18)
                 ^ (sched_reg[1] >> 3))
              + sched_reg[9]
              + (sha_pkg::ror(sched_reg[14], 17) ^ sha_pkg::ror(sched_reg[14], 19)
                 ^ (sched_reg[14] >> 10));
        t1 = work_reg[7]
           + (sha_pkg::ror(work_reg[4], 6) ^ sha_pkg::ror(work_reg[4], 11)
              ^ sha_pkg::ror(work_reg[4], 25))
           + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
           + sha_pkg::ROUND_K[round_reg] + w_cur;
        t2 = (sha_pkg::ror(work_reg[0], 2) ^ sha_pkg::ror(work_reg[0], 13)
              ^ sha_pkg::ror(work_reg[0], 22))
           + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
              ^ (work_reg[1] & work_reg[2]));
    end

    // Schedule window and working registers, without reset. Block bytes land
    // big-endian in the window words; every byte is rewritten before a block
    // is compressed.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            sched_reg[fill_reg[5:2]][8 * (3 - 32'(fill_reg[1:0])) +: 8] <= wr_byte;
        else if (cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
                sched_reg[i] <= sched_reg[i + 1];
            sched_reg[15] <= w_new;
        end
        if (cmd.start_block)
        begin
            for (int i = 0; i < 8; i++)
                work_reg[i] <= hash_reg[i];
        end
        else if (cmd.round_en)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

    // Control state: fill, round counter, bit count, hash words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            round_reg <= '0;
            bits_reg  <= '0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= sha_pkg::hash_init(3'(i));
        end
        else
        begin
            if (cmd.clear_fill)
                fill_reg <= '0;
            else if (wr_en)
                fill_reg <= fill_reg + 6'd1;
            if (cmd.start_block)
                round_reg <= '0;
            else if (cmd.round_en)
                round_reg <= round_reg + 6'd1;
            if (cmd.reinit)
                bits_reg <= '0;
            else if (cmd.count_block)
                bits_reg <= bits_reg + 64'd512;
            else if (cmd.add_tail)
                bits_reg <= bits_reg + {55'd0, fill_reg, 3'd0};
            for (int i = 0; i < 8; i++)
            begin
                if (cmd.reinit)
                    hash_reg[i] <= sha_pkg::hash_init(3'(i));
                else if (cmd.finish_block)
                    hash_reg[i] <= hash_reg[i] + work_reg[i];
            end
        end
    end

    always_comb
    begin
        stat.fill       = fill_reg;
        stat.last_round = (round_reg == 6'd63);
        digest = {hash_reg[0], hash_reg[1], hash_reg[2], hash_reg[3],
                  hash_reg[4], hash_reg[5], hash_reg[6], hash_reg[7]};
    end

endmodule

>>> design/sha_control.sv
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte loading, compression, padding and digest output.
// ----------------------------------------------------------------------------
module sha_control
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 byte_present,
    input  logic                 end_of_message,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [1:0]           word_number,
    output logic                 last_word,
    input  sha_pkg::dp_stat_t    stat,
    output sha_pkg::dp_cmd_t     cmd
);

    sha_pkg::state_t state_reg, state_next;
    logic            started_reg, started_next;   // round pass underway
    logic            final_reg, final_next;       // compression is part of padding
    logic            marked_reg, marked_next;     // pad marker written
    logic            len_here_reg, len_here_next; // this pad block takes the length
    logic            pend_end_reg, pend_end_next; // end flag waiting behind a full block
    logic [1:0]      word_reg, word_next;
    logic            accept;

    assign accept = in_valid && !in_stall;

    // Next-state logic.
    always_comb
    begin
        state_next    = state_reg;
        started_next  = started_reg;
        final_next    = final_reg;
        marked_next   = marked_reg;
        len_here_next = len_here_reg;
        pend_end_next = pend_end_reg;
        word_next     = word_reg;
        unique case (state_reg)
            sha_pkg::ST_COLLECT:
            begin
                if (accept)
                begin
                    if (byte_present && stat.fill == 6'd63)
                    begin
                        state_next    = sha_pkg::ST_ROUNDS;
                        final_next    = 1'b0;
                        pend_end_next = end_of_message;
                        started_next  = 1'b0;
                    end
                    else if (end_of_message)
                    begin
                        state_next  = sha_pkg::ST_PAD;
                        marked_next = 1'b0;
                    end
                end
            end
            sha_pkg::ST_ROUNDS:
            begin
                if (!started_reg)
                    started_next = 1'b1;
                else if (stat.last_round)
                begin
                    started_next = 1'b0;
                    state_next   = sha_pkg::ST_FINISH;
                end
            end
            sha_pkg::ST_FINISH:
            begin
                if (final_reg)
                begin
                    if (len_here_reg)
                    begin
                        state_next = sha_pkg::ST_EMIT;
                        word_next  = '0;
                    end
                    else
                    begin
                        // The length did not fit: one more block of padding.
                        state_next    = sha_pkg::ST_PAD;
                        len_here_next = 1'b1;
                    end
                end
                else if (pend_end_reg)
                begin
                    state_next    = sha_pkg::ST_PAD;
                    marked_next   = 1'b0;
                    pend_end_next = 1'b0;
                end
                else
                    state_next = sha_pkg::ST_COLLECT;
            end
            sha_pkg::ST_PAD:
            begin
                marked_next = 1'b1;
                if (!marked_reg)
                    len_here_next = (stat.fill < 6'(sha_pkg::LEN_OFFSET));
                if (stat.fill == 6'd63)
                begin
                    state_next   = sha_pkg::ST_ROUNDS;
                    final_next   = 1'b1;
                    started_next = 1'b0;
                end
            end
            sha_pkg::ST_EMIT:
            begin
                if (!out_stall)
                begin
                    word_next = word_reg + 2'd1;
                    if (word_reg == 2'd3)
                        state_next = sha_pkg::ST_COLLECT;
                end
            end
            default:
                state_next = sha_pkg::ST_COLLECT;
        endcase
    end

    // Output and command logic.
    always_comb
    begin
        cmd         = '0;
        in_stall    = (state_reg != sha_pkg::ST_COLLECT);
        out_valid   = (state_reg == sha_pkg::ST_EMIT);
        word_number = word_reg;
        last_word   = (word_reg == 2'd3);
        unique case (state_reg)
            sha_pkg::ST_COLLECT:
            begin
                cmd.load_byte = accept && byte_present;
            end
            sha_pkg::ST_ROUNDS:
            begin
                cmd.start_block = !started_reg;
                cmd.round_en    = started_reg;
            end
            sha_pkg::ST_FINISH:
            begin
                cmd.finish_block = 1'b1;
                cmd.count_block  = !final_reg;
            end
            sha_pkg::ST_PAD:
            begin
                // The marker goes at the tail end, which also sets the bit count.
                cmd.pad_write  = 1'b1;
                cmd.pad_mark   = !marked_reg;
                cmd.add_tail   = !marked_reg;
                cmd.pad_len    = len_here_reg;
                cmd.clear_fill = (stat.fill == 6'd63);
            end
            sha_pkg::ST_EMIT:
            begin
                cmd.reinit = !out_stall && (word_reg == 2'd3);
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sha_pkg::ST_COLLECT;
            started_reg  <= 1'b0;
            final_reg    <= 1'b0;
            marked_reg   <= 1'b0;
            len_here_reg <= 1'b0;
            pend_end_reg <= 1'b0;
            word_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            started_reg  <= started_next;
            final_reg    <= final_next;
            marked_reg   <= marked_next;
            len_here_reg <= len_here_next;
            pend_end_reg <= pend_end_next;
            word_reg     <= word_next;
        end
    end

`ifndef SYNTHESIS
    // Input is only taken while collecting.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> state_reg == sha_pkg::ST_COLLECT)
        else $error("word accepted outside collect state");
    // The store is never written during a round pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sha_pkg::ST_ROUNDS |-> !(cmd.load_byte || cmd.pad_write))
        else $error("store written during rounds");
    // Hash words only take a block's result after the last round.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish_block |-> state_reg == sha_pkg::ST_FINISH)
        else $error("hash words updated outside finish state");
    // Digest words leave in order.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && word_reg != 2'd3 |=>
            out_valid && word_reg == $past(word_reg) + 2'd1)
        else $error("digest word order broken");
`endif

endmodule

>>> design/sha256_message_digest_core.sv
// ----------------------------------------------------------------------------
// SHA-256 message digest core
// Hashes a byte stream and returns the digest as four 64-bit words.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  input   | in        | in_valid / in_stall  | data_byte, byte_present, end_of_message
//  output  | out       | out_valid / out_stall| digest_word, word_number, last_word
//
// The 64th byte of a block starts its compression: the working registers are
// loaded, 64 rounds run and the result is added into the hash. An end word
// writes one padding byte per cycle to the end of the block (plus one more
// padding block when the length no longer fits), compresses each padded
// block, then gives four output words. Reset is asynchronous and active low.
// Input is stalled while compressing, padding or emitting.
module sha256_message_digest_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_word,
    output logic [1:0]  word_number,
    output logic        last_word
);

    sha_pkg::dp_cmd_t  cmd;
    sha_pkg::dp_stat_t stat;
    logic [255:0]      digest;

    sha_control u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .word_number    (word_number),
        .last_word      (last_word),
        .stat           (stat),
        .cmd            (cmd)
    );

    sha_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (data_byte),
        .stat      (stat),
        .digest    (digest)
    );

    assign digest_word = digest[255 - 64 * 32'(word_number) -: 64];

endmodule
